### rtl/core/jeo_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// jeo_pkg
// Shared constants, state encoding and control structs for the Josephus
// elimination order block.
// ----------------------------------------------------------------------------
package jeo_pkg;

    localparam int MAX_PEOPLE = 64;
    localparam int SEAT_W     = $clog2(MAX_PEOPLE);
    localparam int PERSON_W   = 7;
    localparam int STEP_W     = 8;
    localparam int ITER_W     = $clog2(STEP_W);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_MOD,
        ST_WALK,
        ST_ELIM,
        ST_SEEK,
        ST_SCAN
    } jeo_state_t;

    // Request to the remainder unit.
    typedef struct packed {
        logic                start;
        logic [STEP_W-1:0]   dividend;
        logic [PERSON_W-1:0] divisor;
    } jeo_mod_req_t;

    // Status from the remainder unit. The remainder is below the divisor,
    // which never exceeds MAX_PEOPLE.
    typedef struct packed {
        logic              done;
        logic [SEAT_W-1:0] remainder;
    } jeo_mod_sts_t;

endpackage

### rtl/core/jeo_mod_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// jeo_mod_unit
// Restoring remainder unit: one dividend bit per cycle; done pulses for one
// cycle with the remainder valid.
// ----------------------------------------------------------------------------
module jeo_mod_unit
    import jeo_pkg::*;
(
    input  logic         aclk,
    input  logic         aresetn,
    input  jeo_mod_req_t req,
    output jeo_mod_sts_t sts
);

    logic                busy_reg, busy_next;
    logic                done_reg, done_next;
    logic [ITER_W-1:0]   iter_reg, iter_next;
    logic [PERSON_W-1:0] rem_reg, rem_next;
    logic [STEP_W-1:0]   dvd_reg, dvd_next;
    logic [PERSON_W-1:0] div_reg, div_next;
    logic [PERSON_W:0]   trial;

    always_comb begin
        busy_next = busy_reg;
        done_next = 1'b0;
        iter_next = iter_reg;
        rem_next  = rem_reg;
        dvd_next  = dvd_reg;
        div_next  = div_reg;
        trial     = {rem_reg, dvd_reg[STEP_W-1]};
        if (req.start) begin
            busy_next = 1'b1;
            iter_next = ITER_W'(STEP_W - 1);
            rem_next  = '0;
            dvd_next  = req.dividend;
            div_next  = req.divisor;
        end else if (busy_reg) begin
            // The partial remainder stays below the divisor, so the shifted
            // trial value always fits one bit wider than the divisor.
            if (trial >= {1'b0, div_reg}) begin
                rem_next = PERSON_W'(trial - {1'b0, div_reg});
            end else begin
                rem_next = PERSON_W'(trial);
            end
            dvd_next = {dvd_reg[STEP_W-2:0], 1'b0};
            iter_next = iter_reg - ITER_W'(1);
            if (iter_reg == '0) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            iter_reg <= '0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            iter_reg <= iter_next;
        end
        rem_reg <= rem_next;
        dvd_reg <= dvd_next;
        div_reg <= div_next;
    end

    assign sts.done      = done_reg;
    assign sts.remainder = rem_reg[SEAT_W-1:0];

endmodule

### rtl/core/josephus_elimination_order.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// josephus_elimination_order
// Each removal waits for the remainder unit, then walks the circle seat by seat.
// Survivors are reported by a scan of one seat per cycle, which holds at a
// survivor while the output register is full.
// Throughput: one start beat per run; s_tready is high only between runs.
// Reset: synchronous, active low; the block returns idle with no result held.
// ----------------------------------------------------------------------------
module josephus_elimination_order
    import jeo_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    // s_tdata fields, low bit up: people_count[6:0], step_count[14:7],
    // survivor_count[21:15], zero pad [23:22].
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [23:0] s_tdata,
    // m_tdata fields, low bit up: person_number[6:0], zero pad [7].
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [7:0]  m_tdata,
    // m_tuser fields, low bit up: survived[0].
    output logic [0:0]  m_tuser,
    // m_tlast carries last_of_run.
    output logic        m_tlast
);

    jeo_state_t state_reg, state_next;

    // Circle state. The alive mask has one bit per seat, bit p for person p+1.
    logic [MAX_PEOPLE-1:0] alive_reg, alive_next;
    logic [SEAT_W-1:0]     cursor_reg, cursor_next;
    logic [PERSON_W-1:0]   remaining_reg, remaining_next;
    logic [PERSON_W-1:0]   surv_reg, surv_next;
    logic [STEP_W-1:0]     stepm1_reg, stepm1_next;
    logic [SEAT_W-1:0]     walk_reg, walk_next;
    logic [SEAT_W-1:0]     scan_reg, scan_next;
    logic [PERSON_W-1:0]   found_reg, found_next;

    // Output register: one result beat waiting for the sink.
    logic                  out_valid_reg, out_valid_next;
    logic [PERSON_W-1:0]   out_person_reg, out_person_next;
    logic                  out_surv_reg, out_surv_next;
    logic                  out_last_reg, out_last_next;
    logic                  out_free;

    // Start beat fields after clamping.
    logic [PERSON_W-1:0]   in_people, in_surv, n_clamp, s_clamp;
    logic [STEP_W-1:0]     in_step, k_clamp;
    logic                  s_accept;

    logic [SEAT_W-1:0]     cursor_inc;
    logic [PERSON_W-1:0]   remaining_dec;

    jeo_mod_req_t mod_req;
    jeo_mod_sts_t mod_sts;

    jeo_mod_unit u_mod (
        .aclk    (aclk),
        .aresetn (aresetn),
        .req     (mod_req),
        .sts     (mod_sts)
    );

    assign in_people = s_tdata[6:0];
    assign in_step   = s_tdata[14:7];
    assign in_surv   = s_tdata[21:15];

    // A circle of zero counts as one, and the size saturates at the seat count.
    // The survivor count is clamped against the clamped circle size.
    always_comb begin
        if (in_people == '0) begin
            n_clamp = PERSON_W'(1);
        end else if (in_people > PERSON_W'(MAX_PEOPLE)) begin
            n_clamp = PERSON_W'(MAX_PEOPLE);
        end else begin
            n_clamp = in_people;
        end
        k_clamp = (in_step == '0) ? STEP_W'(1) : in_step;
        if (in_surv == '0) begin
            s_clamp = PERSON_W'(1);
        end else if (in_surv > n_clamp) begin
            s_clamp = n_clamp;
        end else begin
            s_clamp = in_surv;
        end
    end

    assign s_tready      = (state_reg == ST_IDLE);
    assign s_accept      = s_tvalid && s_tready;
    assign out_free      = !out_valid_reg || m_tready;
    assign cursor_inc    = cursor_reg + SEAT_W'(1);
    assign remaining_dec = remaining_reg - PERSON_W'(1);

    always_comb begin
        state_next      = state_reg;
        alive_next      = alive_reg;
        cursor_next     = cursor_reg;
        remaining_next  = remaining_reg;
        surv_next       = surv_reg;
        stepm1_next     = stepm1_reg;
        walk_next       = walk_reg;
        scan_next       = scan_reg;
        found_next      = found_reg;
        out_valid_next  = out_valid_reg && !m_tready;
        out_person_next = out_person_reg;
        out_surv_next   = out_surv_reg;
        out_last_next   = out_last_reg;
        mod_req.start    = 1'b0;
        mod_req.dividend = stepm1_reg;
        mod_req.divisor  = remaining_reg;

        unique case (state_reg)
            ST_IDLE: begin
                if (s_accept) begin
                    if (n_clamp == PERSON_W'(MAX_PEOPLE)) begin
                        alive_next = '1;
                    end else begin
                        alive_next = (MAX_PEOPLE'(1) << n_clamp) - MAX_PEOPLE'(1);
                    end
                    remaining_next = n_clamp;
                    surv_next      = s_clamp;
                    stepm1_next    = k_clamp - STEP_W'(1);
                    cursor_next    = '0;
                    scan_next      = '0;
                    found_next     = '0;
                    if (n_clamp > s_clamp) begin
                        // The count begins at person 1; find the offset
                        // of the next removal modulo the live people.
                        mod_req.start    = 1'b1;
                        mod_req.dividend = k_clamp - STEP_W'(1);
                        mod_req.divisor  = n_clamp;
                        state_next       = ST_MOD;
                    end else begin
                        state_next = ST_SCAN;
                    end
                end
            end

            ST_MOD: begin
                if (mod_sts.done) begin
                    walk_next  = mod_sts.remainder;
                    state_next = ST_WALK;
                end
            end

            ST_WALK: begin
                // Step one seat a cycle; only live seats use up the count.
                if (walk_reg == '0) begin
                    state_next = ST_ELIM;
                end else begin
                    cursor_next = cursor_inc;
                    if (alive_reg[cursor_inc]) begin
                        walk_next = walk_reg - SEAT_W'(1);
                    end
                end
            end

            ST_ELIM: begin
                if (out_free) begin
                    out_valid_next  = 1'b1;
                    out_person_next = PERSON_W'(cursor_reg) + PERSON_W'(1);
                    out_surv_next   = 1'b0;
                    // At least one person always survives, so a removal
                    // never closes the run.
                    out_last_next   = 1'b0;
                    alive_next[cursor_reg] = 1'b0;
                    remaining_next  = remaining_dec;
                    cursor_next     = cursor_inc;
                    if (remaining_dec > surv_reg) begin
                        state_next = ST_SEEK;
                    end else begin
                        state_next = ST_SCAN;
                    end
                end
            end

            ST_SEEK: begin
                // Move to the next live seat, where the next count begins.
                if (alive_reg[cursor_reg]) begin
                    mod_req.start = 1'b1;
                    state_next    = ST_MOD;
                end else begin
                    cursor_next = cursor_inc;
                end
            end

            ST_SCAN: begin
                // Survivors go out in seat order; the one that completes
                // the count closes the run.
                if (alive_reg[scan_reg]) begin
                    if (out_free) begin
                        out_valid_next  = 1'b1;
                        out_person_next = PERSON_W'(scan_reg) + PERSON_W'(1);
                        out_surv_next   = 1'b1;
                        out_last_next   = (found_reg + PERSON_W'(1) == remaining_reg);
                        found_next      = found_reg + PERSON_W'(1);
                        scan_next       = scan_reg + SEAT_W'(1);
                        if (found_reg + PERSON_W'(1) == remaining_reg) begin
                            state_next = ST_IDLE;
                        end
                    end
                end else begin
                    scan_next = scan_reg + SEAT_W'(1);
                end
            end

            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            alive_reg     <= '0;
            cursor_reg    <= '0;
            remaining_reg <= '0;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg     <= state_next;
            alive_reg     <= alive_next;
            cursor_reg    <= cursor_next;
            remaining_reg <= remaining_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        surv_reg       <= surv_next;
        stepm1_reg     <= stepm1_next;
        walk_reg       <= walk_next;
        scan_reg       <= scan_next;
        found_reg      <= found_next;
        out_person_reg <= out_person_next;
        out_surv_reg   <= out_surv_next;
        out_last_reg   <= out_last_next;
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {1'b0, out_person_reg};
    assign m_tuser  = out_surv_reg;
    assign m_tlast  = out_last_reg;

    // The live count always matches the number of set bits in the mask.
    a_count_matches_mask: assert property (@(posedge aclk) disable iff (!aresetn)
        $countones(alive_reg) == 32'(remaining_reg))
        else $error("live count disagrees with alive mask");

    // A removal only ever takes a live seat.
    a_elim_live_seat: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_ELIM) |-> alive_reg[cursor_reg])
        else $error("removal at a seat that is already empty");

    // Elimination never goes below the survivor count during a run.
    a_not_below_survivors: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg != ST_IDLE) |-> (remaining_reg >= surv_reg))
        else $error("live count fell below survivor count");

    // The remainder unit answers only while the sequencer waits for it.
    a_mod_done_in_mod: assert property (@(posedge aclk) disable iff (!aresetn)
        mod_sts.done |-> (state_reg == ST_MOD))
        else $error("remainder result outside of the wait state");

endmodule
